FILE: hdl/gsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsp_pkg
// Shared sizes, types and codes of the gshare predictor with target buffer.
// ----------------------------------------------------------------------------
package gsp_pkg;

  // table sizes
  localparam int BTB_ENTRIES = 1024;
  localparam int PHT_ENTRIES = 256;
  localparam int BTB_IDX_W   = $clog2(BTB_ENTRIES);
  localparam int PHT_IDX_W   = $clog2(PHT_ENTRIES);
  localparam int HIST_W      = 8;

  // one sweep after reset clears both tables
  localparam int CLEAR_DEPTH = (BTB_ENTRIES > PHT_ENTRIES) ? BTB_ENTRIES : PHT_ENTRIES;
  localparam int CLR_W       = $clog2(CLEAR_DEPTH);

  // two-entry queues on both sides of the back end
  localparam int QCNT_W = 2;
  localparam logic [QCNT_W-1:0] QUEUE_DEPTH = 2'd2;

  localparam logic [63:0] PC_STEP = 64'd4;

  // counter levels
  localparam logic [1:0] CTR_MIN  = 2'd0;
  localparam logic [1:0] CTR_MAX  = 2'd3;

  // item modes
  localparam logic MODE_PREDICT = 1'b0;
  localparam logic MODE_UPDATE  = 1'b1;

  // branch kinds
  localparam logic KIND_COND   = 1'b0;
  localparam logic KIND_UNCOND = 1'b1;

  // classified input word
  typedef struct packed {
    logic                 is_update;
    logic [63:0]          pc;
    logic [63:0]          pc_plus4;
    logic                 seq_ok;
    logic                 kind;
    logic                 taken;
    logic [63:0]          target;
    logic [BTB_IDX_W-1:0] btb_idx;
  } cmd_t;

  // result word
  typedef struct packed {
    logic [63:0] next_pc;
    logic        pc_changed;
    logic        mispredict;
  } res_t;

  // target buffer entry
  typedef struct packed {
    logic        valid;
    logic        cond;
    logic [63:0] tag;
    logic [63:0] target;
  } btb_entry_t;

  // back end status toward the front end
  typedef struct packed {
    logic take;
    logic clearing;
  } back_stat_t;

endpackage

FILE: hdl/gshare_predictor_with_btb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gshare_predictor_with_btb
// Gshare direction predictor with a direct-mapped branch target buffer.
// ----------------------------------------------------------------------------
// Input channel: push/full. A word with mode 0 asks for the next fetch
// address of pc; mode 1 trains the tables with a resolved branch.
// Result channel: empty/pop. The oldest result sits on next_pc, pc_changed
// and mispredict while empty is low; pop takes it. One result per word,
// in input order.
// Order: an accepted word waits in the input queue; the back end reads the
// tables for it, then resolves and writes back the same entry and queues
// the result. It takes no new word until it is through with the last one.
// Reset: after rst the back end sweeps both tables, one entry per cycle up to
// the larger table's depth (1024 entries); full stays high during the sweep.
// Stall: when the receiver stops popping, the two-entry result queue fills,
// the back end stops, and then the two-entry input queue fills and raises full.
// ----------------------------------------------------------------------------
module gshare_predictor_with_btb (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        mode,
  input  logic [63:0] pc,
  input  logic        sequential_ok,
  input  logic        branch_kind,
  input  logic        taken,
  input  logic [63:0] actual_target,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] next_pc,
  output logic        pc_changed,
  output logic        mispredict
);

  gsp_pkg::back_stat_t stat;
  gsp_pkg::cmd_t       cmd;
  gsp_pkg::res_t       res;
  gsp_pkg::res_t       head;
  logic                cmd_valid;
  logic                res_full;
  logic                res_push;

  // decode and queue incoming words
  gsp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .mode          (mode),
    .pc            (pc),
    .sequential_ok (sequential_ok),
    .branch_kind   (branch_kind),
    .taken         (taken),
    .actual_target (actual_target),
    .stat          (stat),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd)
  );

  // table lookup, training and install
  gsp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .stat      (stat),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  // results waiting for the receiver
  gsp_result_queue u_result_queue (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  assign next_pc    = head.next_pc;
  assign pc_changed = head.pc_changed;
  assign mispredict = head.mispredict;

endmodule

FILE: hdl/gsp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsp_front
// Accepts input words, decodes them into commands and queues them for the
// back end in a two-entry queue.
// ----------------------------------------------------------------------------
module gsp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic                mode,
  input  logic [63:0]         pc,
  input  logic                sequential_ok,
  input  logic                branch_kind,
  input  logic                taken,
  input  logic [63:0]         actual_target,
  input  gsp_pkg::back_stat_t stat,
  output logic                cmd_valid,
  output gsp_pkg::cmd_t       cmd
);

  gsp_pkg::cmd_t                   slots [2];
  gsp_pkg::cmd_t                   decoded;
  logic                            wr_ptr;
  logic                            rd_ptr;
  logic [gsp_pkg::QCNT_W-1:0]      count;
  logic                            do_push;

  // decode the incoming word
  always_comb begin
    decoded.is_update = (mode == gsp_pkg::MODE_UPDATE);
    decoded.pc        = pc;
    decoded.pc_plus4  = pc + gsp_pkg::PC_STEP;
    decoded.seq_ok    = sequential_ok;
    decoded.kind      = branch_kind;
    decoded.taken     = taken;
    decoded.target    = actual_target;
    decoded.btb_idx   = pc[gsp_pkg::BTB_IDX_W+1:2];
  end

  // no words taken while the tables are being cleared
  assign full      = (count == gsp_pkg::QUEUE_DEPTH) || stat.clearing;
  assign do_push   = push && !full;
  assign cmd_valid = (count != '0);
  assign cmd       = slots[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= decoded;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (stat.take) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + gsp_pkg::QCNT_W'(do_push) - gsp_pkg::QCNT_W'(stat.take);
    end
  end

endmodule

FILE: hdl/gsp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsp_back
// Holds the history, pattern table and target buffer; runs one command at a
// time as a table read followed by a resolve and write-back.
// ----------------------------------------------------------------------------
module gsp_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  gsp_pkg::cmd_t       cmd,
  output gsp_pkg::back_stat_t stat,
  input  logic                res_full,
  output logic                res_push,
  output gsp_pkg::res_t       res
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK
  } state_t;

  state_t                              state;
  gsp_pkg::cmd_t                       cur;
  logic [gsp_pkg::HIST_W-1:0]          history;
  logic [gsp_pkg::CLR_W-1:0]           clr_idx;

  gsp_pkg::btb_entry_t                 btb_mem [gsp_pkg::BTB_ENTRIES];
  logic [1:0]                          pht_mem [gsp_pkg::PHT_ENTRIES];
  gsp_pkg::btb_entry_t                 btb_q;
  logic [1:0]                          ctr_q;

  logic [63:0]                         pht_mix;
  logic [gsp_pkg::PHT_IDX_W-1:0]       pht_rd_idx;
  logic [gsp_pkg::PHT_IDX_W-1:0]       cur_pht_idx;
  logic                                take;
  logic                                hit;
  logic [1:0]                          ctr_next;
  logic                                btb_we;
  logic                                pht_we;
  logic [gsp_pkg::BTB_IDX_W-1:0]       btb_wr_idx;
  logic [gsp_pkg::PHT_IDX_W-1:0]       pht_wr_idx;
  gsp_pkg::btb_entry_t                 btb_wdata;
  logic [1:0]                          pht_wdata;

  function automatic logic [gsp_pkg::PHT_IDX_W-1:0] pht_idx_of(
    input logic [63:0]                addr,
    input logic [gsp_pkg::HIST_W-1:0] hist
  );
    logic [63:0] mix;
    mix = (addr >> 2) ^ 64'(hist);
    return mix[gsp_pkg::PHT_IDX_W-1:0];
  endfunction

  // gshare index from the current history
  assign pht_mix    = (cmd.pc >> 2) ^ 64'(history);
  assign pht_rd_idx = pht_mix[gsp_pkg::PHT_IDX_W-1:0];

  assign take          = (state == ST_IDLE) && cmd_valid && !res_full;
  assign stat.take     = take;
  assign stat.clearing = (state == ST_CLEAR);

  // resolve the looked-up entry
  always_comb begin
    hit       = btb_q.valid && (btb_q.tag == cur.pc);
    ctr_next  = ctr_q;
    res       = '0;
    btb_we    = 1'b0;
    pht_we    = 1'b0;
    btb_wdata = '0;
    if (!cur.is_update) begin
      if (hit && (!btb_q.cond || ctr_q[1])) begin
        res.next_pc    = btb_q.target;
        res.pc_changed = 1'b1;
      end else if (cur.seq_ok) begin
        res.next_pc    = cur.pc_plus4;
        res.pc_changed = 1'b1;
      end
    end else begin
      // train the counter of a conditional entry
      if (btb_q.cond) begin
        pht_we = 1'b1;
        if (cur.taken) begin
          if (ctr_q != gsp_pkg::CTR_MAX) begin
            ctr_next = ctr_q + 2'd1;
          end
          res.mispredict = !ctr_q[1];
        end else begin
          if (ctr_q != gsp_pkg::CTR_MIN) begin
            ctr_next = ctr_q - 2'd1;
          end
          res.mispredict = ctr_q[1];
        end
      end
      // install a taken branch into an empty entry
      if (cur.taken && !btb_q.valid) begin
        btb_we           = 1'b1;
        btb_wdata.valid  = 1'b1;
        btb_wdata.cond   = (cur.kind == gsp_pkg::KIND_COND);
        btb_wdata.tag    = cur.pc;
        btb_wdata.target = cur.target;
        if (cur.kind == gsp_pkg::KIND_COND) begin
          res.mispredict = 1'b1;
        end
      end
    end
    if (state != ST_LOOK) begin
      btb_we = 1'b0;
      pht_we = 1'b0;
    end
    if (state == ST_CLEAR) begin
      btb_we    = 1'b1;
      pht_we    = 1'b1;
      btb_wdata = '0;
    end
  end

  assign res_push = (state == ST_LOOK);

  // write port selection: clearing sweep or write-back
  assign cur_pht_idx = pht_idx_of(cur.pc, history);
  assign btb_wr_idx  = (state == ST_CLEAR) ? clr_idx[gsp_pkg::BTB_IDX_W-1:0] : cur.btb_idx;
  assign pht_wr_idx  = (state == ST_CLEAR) ? clr_idx[gsp_pkg::PHT_IDX_W-1:0] : cur_pht_idx;
  assign pht_wdata   = (state == ST_CLEAR) ? gsp_pkg::CTR_MIN : ctr_next;

  // target buffer memory
  always_ff @(posedge clk) begin
    if (btb_we) begin
      btb_mem[btb_wr_idx] <= btb_wdata;
    end
    if (take) begin
      btb_q <= btb_mem[cmd.btb_idx];
    end
  end

  // pattern table memory
  always_ff @(posedge clk) begin
    if (pht_we) begin
      pht_mem[pht_wr_idx] <= pht_wdata;
    end
    if (take) begin
      ctr_q <= pht_mem[pht_rd_idx];
    end
  end

  // sequencer, history and clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      history <= '0;
      clr_idx <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + gsp_pkg::CLR_W'(1);
          if (clr_idx == gsp_pkg::CLR_W'(gsp_pkg::CLEAR_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (take) begin
            state <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          if (cur.is_update && (cur.kind == gsp_pkg::KIND_COND)) begin
            history <= {history[gsp_pkg::HIST_W-2:0], cur.taken};
          end
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // command held during the lookup
  always_ff @(posedge clk) begin
    if (take) begin
      cur <= cmd;
    end
  end

  // a resolve always follows a lookup issued in idle
  a_look_after_idle: assert property (@(posedge clk) disable iff (rst)
    state == ST_LOOK |-> $past(take))
    else $error("resolve without a lookup");

  // no command is taken during the clearing sweep
  a_no_take_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !take)
    else $error("command taken while clearing");

  // a predict result never flags a mispredict
  a_predict_no_miss: assert property (@(posedge clk) disable iff (rst)
    res_push && !cur.is_update |-> !res.mispredict)
    else $error("mispredict on a predict word");

  // an update result never redirects fetch
  a_update_no_redirect: assert property (@(posedge clk) disable iff (rst)
    res_push && cur.is_update |-> !res.pc_changed && (res.next_pc == '0))
    else $error("redirect on an update word");

endmodule

FILE: hdl/gsp_result_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsp_result_queue
// Two-entry queue that holds finished results until the receiver pops them.
// ----------------------------------------------------------------------------
module gsp_result_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               res_push,
  input  gsp_pkg::res_t      res,
  output logic               res_full,
  input  logic               pop,
  output logic               empty,
  output gsp_pkg::res_t      head
);

  gsp_pkg::res_t               slots [2];
  logic                        wr_ptr;
  logic                        rd_ptr;
  logic [gsp_pkg::QCNT_W-1:0]  count;
  logic                        do_pop;

  assign empty    = (count == '0);
  assign res_full = (count == gsp_pkg::QUEUE_DEPTH);
  assign do_pop   = pop && !empty;
  assign head     = slots[rd_ptr];

  // result storage
  always_ff @(posedge clk) begin
    if (res_push) begin
      slots[wr_ptr] <= res;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (res_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + gsp_pkg::QCNT_W'(res_push) - gsp_pkg::QCNT_W'(do_pop);
    end
  end

endmodule

FILE: tb/tb_gshare_predictor_with_btb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gshare_predictor_with_btb
// Self-checking bench for the gshare predictor with branch target buffer.
// A short table of directed words covers the corner cases. Random words
// follow, drawn mostly from a small set of branch addresses so that the
// counters train and the buffer fills. Every word is also run through a
// local copy of the predictor tables. Each popped result is checked against
// the oldest expected result.
// ----------------------------------------------------------------------------
module tb_gshare_predictor_with_btb;

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 10;
  localparam int RANDOM_WORDS   = 450;
  localparam int DRAIN_CYCLES   = 16;
  localparam int TIMEOUT_CYCLES = 200000;
  localparam int IDLE_PCT       = 38;
  localparam int POOL_SIZE      = 16;
  localparam logic [1:0] CTR_TAKEN = 2'd2;

  // one input word
  typedef struct packed {
    logic        mode;
    logic [63:0] pc;
    logic        seq_ok;
    logic        kind;
    logic        taken;
    logic [63:0] target;
  } word_t;

  // directed row: the word, and its result where it is plain to see
  typedef struct packed {
    word_t         w;
    logic          known;
    gsp_pkg::res_t want;
  } stim_row_t;

  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] TGT_A    = 64'h0000_0000_DEAD_BEE0;
  localparam logic [63:0] TGT_B    = 64'hFFFF_FFFF_FFFF_FFF0;
  localparam int NUM_DIRECTED = 25;

  localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
    // empty tables: no redirect, then pc+4 and its wrap
    '{'{gsp_pkg::MODE_PREDICT, 64'h0, 1'b0, gsp_pkg::KIND_COND, 1'b0, 64'h0}, 1'b1,
      '{64'h0, 1'b0, 1'b0}},
    '{'{gsp_pkg::MODE_PREDICT, 64'h0, 1'b1, gsp_pkg::KIND_COND, 1'b0, 64'h0}, 1'b1,
      '{64'h4, 1'b1, 1'b0}},
    '{'{gsp_pkg::MODE_PREDICT, ALL_ONES, 1'b1, gsp_pkg::KIND_UNCOND, 1'b1, ALL_ONES}, 1'b1,
      '{64'h3, 1'b1, 1'b0}},
    // not-taken conditional on an empty entry: nothing happens
    '{'{gsp_pkg::MODE_UPDATE, 64'h100, 1'b1, gsp_pkg::KIND_COND, 1'b0, TGT_A}, 1'b1,
      '{64'h0, 1'b0, 1'b0}},
    // unconditional install and its hit
    '{'{gsp_pkg::MODE_UPDATE, 64'h200, 1'b0, gsp_pkg::KIND_UNCOND, 1'b1, TGT_A}, 1'b1,
      '{64'h0, 1'b0, 1'b0}},
    '{'{gsp_pkg::MODE_PREDICT, 64'h200, 1'b0, gsp_pkg::KIND_COND, 1'b0, 64'h0}, 1'b1,
      '{TGT_A, 1'b1, 1'b0}},
    // conditional install flags a mispredict
    '{'{gsp_pkg::MODE_UPDATE, 64'h300, 1'b0, gsp_pkg::KIND_COND, 1'b1, TGT_B}, 1'b1,
      '{64'h0, 1'b0, 1'b1}},
    '{'{gsp_pkg::MODE_PREDICT, 64'h300, 1'b1, gsp_pkg::KIND_COND, 1'b0, 64'h0}, 1'b0, '0},
    // repeated taken updates of the same conditional branch
    '{'{gsp_pkg::MODE_UPDATE, 64'h300, 1'b0, gsp_pkg::KIND_COND, 1'b1, TGT_B}, 1'b0, '0},
    '{'{gsp_pkg::MODE_UPDATE, 64'h300, 1'b0, gsp_pkg::KIND_COND, 1'b1, TGT_B}, 1'b0, '0},
    '{'{gsp_pkg::MODE_UPDATE, 64'h300, 1'b0, gsp_pkg::KIND_COND, 1'b1, TGT_B}, 1'b0, '0},
    '{'{gsp_pkg::MODE_PREDICT, 64'h300, 1'b0, gsp_pkg::KIND_COND, 1'b0, 64'h0}, 1'b0, '0},
    // repeated not-taken updates of the same conditional branch
    '{'{gsp_pkg::MODE_UPDATE, 64'h300, 1'b1, gsp_pkg::KIND_COND, 1'b0, TGT_B}, 1'b0, '0},
    '{'{gsp_pkg::MODE_UPDATE, 64'h300, 1'b1, gsp_pkg::KIND_COND, 1'b0, TGT_B}, 1'b0, '0},
    '{'{gsp_pkg::MODE_UPDATE, 64'h300, 1'b1, gsp_pkg::KIND_COND, 1'b0, TGT_B}, 1'b0, '0},
    '{'{gsp_pkg::MODE_UPDATE, 64'h300, 1'b1, gsp_pkg::KIND_COND, 1'b0, TGT_B}, 1'b0, '0},
    // tag mismatch on a valid entry never uses the stored target
    '{'{gsp_pkg::MODE_PREDICT, 64'h1300, 1'b0, gsp_pkg::KIND_COND, 1'b0, 64'h0}, 1'b1,
      '{64'h0, 1'b0, 1'b0}},
    '{'{gsp_pkg::MODE_UPDATE, 64'h1300, 1'b0, gsp_pkg::KIND_COND, 1'b1, TGT_A}, 1'b0, '0},
    '{'{gsp_pkg::MODE_PREDICT, 64'h1300, 1'b1, gsp_pkg::KIND_COND, 1'b0, 64'h0}, 1'b1,
      '{64'h1304, 1'b1, 1'b0}},
    // top address and top target
    '{'{gsp_pkg::MODE_UPDATE, ALL_ONES, 1'b0, gsp_pkg::KIND_UNCOND, 1'b1, ALL_ONES}, 1'b1,
      '{64'h0, 1'b0, 1'b0}},
    '{'{gsp_pkg::MODE_PREDICT, ALL_ONES, 1'b0, gsp_pkg::KIND_COND, 1'b0, 64'h0}, 1'b1,
      '{ALL_ONES, 1'b1, 1'b0}},
    // unconditional not taken leaves everything alone
    '{'{gsp_pkg::MODE_UPDATE, 64'h400, 1'b0, gsp_pkg::KIND_UNCOND, 1'b0, TGT_A}, 1'b1,
      '{64'h0, 1'b0, 1'b0}},
    // conditional install with a zero target, then no replacement
    '{'{gsp_pkg::MODE_UPDATE, 64'h500, 1'b0, gsp_pkg::KIND_COND, 1'b1, 64'h0}, 1'b1,
      '{64'h0, 1'b0, 1'b1}},
    '{'{gsp_pkg::MODE_UPDATE, 64'h500, 1'b0, gsp_pkg::KIND_COND, 1'b1, ALL_ONES}, 1'b0, '0},
    '{'{gsp_pkg::MODE_PREDICT, 64'h500, 1'b1, gsp_pkg::KIND_COND, 1'b0, 64'h0}, 1'b0, '0}
  };

  logic        clk;
  logic        rst           = 1'b1;
  logic        push          = 1'b0;
  logic        mode          = gsp_pkg::MODE_PREDICT;
  logic [63:0] pc            = '0;
  logic        sequential_ok = 1'b0;
  logic        branch_kind   = gsp_pkg::KIND_COND;
  logic        taken         = 1'b0;
  logic [63:0] actual_target = '0;
  logic        pop           = 1'b0;
  logic        full;
  logic        empty;
  logic [63:0] next_pc;
  logic        pc_changed;
  logic        mispredict;

  // local copy of the predictor tables
  logic [gsp_pkg::HIST_W-1:0] history_copy;
  logic [1:0]                 counter_copy [gsp_pkg::PHT_ENTRIES];
  gsp_pkg::btb_entry_t        buffer_copy  [gsp_pkg::BTB_ENTRIES];

  gsp_pkg::res_t pending_outcomes [$];
  logic        steady = 1'b0;
  int          fault_count      = 0;
  int          predict_words    = 0;
  int          update_words     = 0;
  int          target_redirects = 0;
  int          mispredicts_seen = 0;
  logic [63:0] pool_pc     [POOL_SIZE];
  logic [63:0] pool_target [POOL_SIZE];
  logic        pool_kind   [POOL_SIZE];
  int          pool_bias   [POOL_SIZE];

  gshare_predictor_with_btb u_dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .mode         (mode),
    .pc           (pc),
    .sequential_ok(sequential_ok),
    .branch_kind  (branch_kind),
    .taken        (taken),
    .actual_target(actual_target),
    .empty        (empty),
    .pop          (pop),
    .next_pc      (next_pc),
    .pc_changed   (pc_changed),
    .mispredict   (mispredict)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // next fetch address or training outcome of one word, updating the copy
  function automatic gsp_pkg::res_t fetch_outcome(input word_t w);
    logic [gsp_pkg::BTB_IDX_W-1:0] b;
    logic [gsp_pkg::PHT_IDX_W-1:0] p;
    logic [1:0]                    ctr;
    gsp_pkg::res_t                 r;
    b   = w.pc[gsp_pkg::BTB_IDX_W+1:2];
    p   = w.pc[gsp_pkg::PHT_IDX_W+1:2] ^ gsp_pkg::PHT_IDX_W'(history_copy);
    ctr = counter_copy[p];
    r   = '0;
    if (w.mode == gsp_pkg::MODE_PREDICT) begin
      if (buffer_copy[b].valid && buffer_copy[b].tag == w.pc &&
          (!buffer_copy[b].cond || ctr >= CTR_TAKEN)) begin
        r.next_pc    = buffer_copy[b].target;
        r.pc_changed = 1'b1;
        target_redirects++;
      end else if (w.seq_ok) begin
        r.next_pc    = w.pc + gsp_pkg::PC_STEP;
        r.pc_changed = 1'b1;
      end
    end else begin
      // counter trains on the entry's conditional bit alone
      if (buffer_copy[b].cond) begin
        if (w.taken) begin
          if (ctr != gsp_pkg::CTR_MAX) counter_copy[p] = ctr + 2'd1;
          if (ctr < CTR_TAKEN) r.mispredict = 1'b1;
        end else begin
          if (ctr != gsp_pkg::CTR_MIN) counter_copy[p] = ctr - 2'd1;
          if (ctr >= CTR_TAKEN) r.mispredict = 1'b1;
        end
      end
      if (w.kind == gsp_pkg::KIND_COND)
        history_copy = {history_copy[gsp_pkg::HIST_W-2:0], w.taken};
      // taken branches fill empty entries only
      if (w.taken && !buffer_copy[b].valid) begin
        buffer_copy[b].valid  = 1'b1;
        buffer_copy[b].tag    = w.pc;
        buffer_copy[b].cond   = (w.kind == gsp_pkg::KIND_COND);
        buffer_copy[b].target = w.target;
        if (w.kind == gsp_pkg::KIND_COND) r.mispredict = 1'b1;
      end
    end
    return r;
  endfunction

  // offer one word, after a random gap unless steady, and record its result once accepted
  task automatic drive_word(input word_t w, input logic known, input gsp_pkg::res_t want);
    gsp_pkg::res_t r;
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push          <= 1'b1;
    mode          <= w.mode;
    pc            <= w.pc;
    sequential_ok <= w.seq_ok;
    branch_kind   <= w.kind;
    taken         <= w.taken;
    actual_target <= w.target;
    do @(posedge clk); while (full);
    r = fetch_outcome(w);
    if (w.mode == gsp_pkg::MODE_PREDICT) predict_words++;
    else update_words++;
    pending_outcomes.push_back(known ? want : r);
  endtask

  // stimulus
  initial begin : stimulus
    word_t w;
    int    slot;
    history_copy = '0;
    for (int k = 0; k < gsp_pkg::PHT_ENTRIES; k++) counter_copy[k] = gsp_pkg::CTR_MIN;
    for (int k = 0; k < gsp_pkg::BTB_ENTRIES; k++) buffer_copy[k] = '0;

    // branch set: mostly conditional, some sharing a buffer slot with a new tag
    for (int k = 0; k < POOL_SIZE; k++) begin
      pool_pc[k] = {$urandom, $urandom};
      if (k % 4 == 3)
        pool_pc[k] = pool_pc[k-1] ^
                     (64'd1 << (gsp_pkg::BTB_IDX_W + 2 + $urandom_range(0, 49)));
      pool_target[k] = {$urandom, $urandom};
      pool_kind[k]   = ($urandom_range(0, 99) < 75) ? gsp_pkg::KIND_COND
                                                     : gsp_pkg::KIND_UNCOND;
      pool_bias[k]   = $urandom_range(10, 95);
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) drive_word(DIRECTED[i].w, DIRECTED[i].known, DIRECTED[i].want);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      steady <= (i >= 100 && i < 200);
      // hold off until the block has drained completely
      if (i == 300) begin
        push <= 1'b0;
        do @(posedge clk); while (pending_outcomes.size() != 0);
      end
      slot     = $urandom_range(0, POOL_SIZE - 1);
      w.mode   = 1'($urandom_range(0, 1));
      w.seq_ok = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < 80) begin
        w.pc     = pool_pc[slot];
        w.target = ($urandom_range(0, 99) < 85) ? pool_target[slot] : {$urandom, $urandom};
        w.kind   = ($urandom_range(0, 99) < 90) ? pool_kind[slot] : ~pool_kind[slot];
        w.taken  = ($urandom_range(0, 99) < pool_bias[slot]);
      end else begin
        w.pc     = {$urandom, $urandom};
        w.target = {$urandom, $urandom};
        w.kind   = 1'($urandom_range(0, 1));
        w.taken  = 1'($urandom_range(0, 1));
      end
      drive_word(w, 1'b0, '0);
    end

    // drain and finish
    push <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d predict and %0d update words: %0d buffer redirects, %0d mispredicts",
             predict_words, update_words, target_redirects, mispredicts_seen);
    if (fault_count == 0) begin
      $display("[gshare_predictor_with_btb] OK");
    end else begin
      $display("[gshare_predictor_with_btb] ERROR");
    end
    $finish;
  end

  // result side: random pop, compare each popped word with the oldest expected
  always @(posedge clk) begin
    gsp_pkg::res_t got;
    gsp_pkg::res_t exp_r;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        got = {next_pc, pc_changed, mispredict};
        if (pending_outcomes.size() == 0) begin
          fault_count++;
          $display("%0t: result with nothing expected: next_pc=%h pc_changed=%b mispredict=%b",
                   $realtime, next_pc, pc_changed, mispredict);
        end else begin
          exp_r = pending_outcomes.pop_front();
          if (got.mispredict === 1'b1) mispredicts_seen++;
          if (got !== exp_r) begin
            fault_count++;
            $display("%0t: mismatch: expected next_pc=%h pc_changed=%b mispredict=%b",
                     $realtime, exp_r.next_pc, exp_r.pc_changed, exp_r.mispredict);
            $display("%0t:           actual   next_pc=%h pc_changed=%b mispredict=%b",
                     $realtime, got.next_pc, got.pc_changed, got.mispredict);
          end
        end
      end
      pop <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // watchdog
  initial begin
    #(2 * CLK_HALF * TIMEOUT_CYCLES);
    $display("[gshare_predictor_with_btb] ERROR");
    $finish;
  end

endmodule
